### rtl/binary_trie_longest_prefix_match_unit_macros.svh
// Assertion macros for the binary trie longest prefix match unit.
// Used by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef BINARY_TRIE_LONGEST_PREFIX_MATCH_UNIT_MACROS_SVH
`define BINARY_TRIE_LONGEST_PREFIX_MATCH_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BTLPM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define BTLPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/btlpm_pkg.sv
// Shared types and constants of the binary trie longest prefix match unit.
// No dependencies.
`default_nettype none

package btlpm_pkg;

  // Stream widths
  localparam int IN_DATA_W  = 168;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 3;
  localparam int ADDR_W     = 128;

  // Operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [2:0] STATUS_INSERTED = 3'd0;
  localparam logic [2:0] STATUS_KEPT     = 3'd1;
  localparam logic [2:0] STATUS_FULL     = 3'd2;
  localparam logic [2:0] STATUS_TOO_LONG = 3'd3;
  localparam logic [2:0] STATUS_DONE     = 3'd4;

  // Trie depths
  localparam logic [7:0] V4_BITS = 8'd32;
  localparam logic [7:0] V6_BITS = 8'd128;

  // Control of the address shift unit
  typedef struct packed {
    logic load;
    logic shift;
  } shift_ctrl_t;

endpackage

`default_nettype wire

### rtl/btlpm_node_ram.sv
// Trie node pool: one write port, one registered read port.
// No dependencies.
`default_nettype none

module btlpm_node_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 57
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/btlpm_addr_shift.sv
// Address shift unit: presents the address bit of the current trie depth.
// Depends on btlpm_pkg.
`default_nettype none

module btlpm_addr_shift (
  input  wire logic                          clk,
  input  wire btlpm_pkg::shift_ctrl_t        ctrl,
  input  wire logic [btlpm_pkg::ADDR_W-1:0]  load_addr,
  output logic                               msb
);

  logic [btlpm_pkg::ADDR_W-1:0] sh_r;

  // Load the full address, then move one bit per trie level
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sh_r <= load_addr;
    end else if (ctrl.shift) begin
      sh_r <= {sh_r[btlpm_pkg::ADDR_W-2:0], 1'b0};
    end
  end

  assign msb = sh_r[btlpm_pkg::ADDR_W-1];

endmodule

`default_nettype wire

### rtl/binary_trie_longest_prefix_match_unit.sv
// Binary trie longest prefix match unit for IPv4 and IPv6 over one node pool.
// Per operation, one trie level per cycle: a lookup walks down to the depth
// it reaches; an insert walks the existing path, checks the pool, then writes
// the value into an existing node, or sets the root or links the deepest node
// and writes each new node. The pace is set by the node memory, read or written
// once per level, under one sequencer. Clear, unused operations, over-long
// prefixes and lookups of an empty trie go from the accepting state straight
// to the result. A result may also wait in the output register for out_tready.
// One operation is in flight at a time; a finished result sits in the output
// register so the next operation may be taken while it waits.
// Clear only resets the roots and the free pointer, so it needs no pass over
// the pool.
// Depends on btlpm_pkg, btlpm_node_ram, btlpm_addr_shift and the macro header.
`default_nettype none

`include "binary_trie_longest_prefix_match_unit_macros.svh"

module binary_trie_longest_prefix_match_unit #(
  parameter int NODES      = 4096,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tdata: addr_high[63:0], addr_low[127:64], prefix_len[135:128],
  //           value[167:136]
  // in_tuser: op[1:0], is_ipv6[2]
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [btlpm_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire logic [btlpm_pkg::IN_USER_W-1:0]   in_tuser,
  // out_tdata: hit[0], match_value[32:1], zero[39:33]
  // out_tuser: status[2:0]
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [btlpm_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic [btlpm_pkg::OUT_USER_W-1:0]       out_tuser
);

  localparam int IW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);
  localparam int NW = 2 * IW + 1 + VALUE_BITS;
  localparam logic [CW:0]           NODES_W  = (CW + 1)'(NODES);
  localparam logic [IW-1:0]         NULL_IDX = '0;
  localparam logic [VALUE_BITS-1:0] ZERO_VAL = '0;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_LK_WALK  = 7'b0000010,
    ST_IN_WALK  = 7'b0000100,
    ST_IN_CHECK = 7'b0001000,
    ST_IN_LINK  = 7'b0010000,
    ST_IN_ALLOC = 7'b0100000,
    ST_DONE     = 7'b1000000
  } state_t;

  // Input field split
  logic [1:0]            in_op;
  logic                  in_is_ipv6;
  logic [63:0]           in_addr_high;
  logic [63:0]           in_addr_low;
  logic [7:0]            in_prefix_len;
  logic [31:0]           in_value;

  assign in_op         = in_tuser[1:0];
  assign in_is_ipv6    = in_tuser[2];
  assign in_addr_high  = in_tdata[63:0];
  assign in_addr_low   = in_tdata[127:64];
  assign in_prefix_len = in_tdata[135:128];
  assign in_value      = in_tdata[167:136];

  // Control state
  state_t          state_r, state_nxt;
  logic [IW-1:0]   root_v4_r, root_v4_nxt;
  logic [IW-1:0]   root_v6_r, root_v6_nxt;
  logic [CW-1:0]   next_free_r, next_free_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Per-operation working registers
  logic                  is_v6_r, is_v6_nxt;
  logic [7:0]            plen_r, plen_nxt;
  logic [7:0]            width_r, width_nxt;
  logic [7:0]            depth_r, depth_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [IW-1:0]         cur_r, cur_nxt;
  logic                  root_empty_r, root_empty_nxt;
  logic                  hit_r, hit_nxt;
  logic [VALUE_BITS-1:0] mval_r, mval_nxt;
  logic [2:0]            status_r, status_nxt;

  // Output register
  logic [2:0]            out_status_r, out_status_nxt;
  logic                  out_hit_r, out_hit_nxt;
  logic [31:0]           out_mv_r, out_mv_nxt;

  // Memory and shift unit connections
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [NW-1:0]         wr_data;
  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic [NW-1:0]         rd_data;
  btlpm_pkg::shift_ctrl_t sh_ctrl;
  logic                  sh_bit;

  // Node word fields
  logic [VALUE_BITS-1:0] nd_val;
  logic                  nd_hv;
  logic [IW-1:0]         nd_c0;
  logic [IW-1:0]         nd_c1;
  logic [IW-1:0]         nd_next;
  logic [IW-1:0]         root_sel;
  logic [IW-1:0]         nf_idx;
  logic [IW-1:0]         nf_plus;
  logic [7:0]            in_width;
  logic [7:0]            needed;
  logic                  pool_over;

  assign nd_val   = rd_data[VALUE_BITS-1:0];
  assign nd_hv    = rd_data[VALUE_BITS];
  assign nd_c0    = rd_data[VALUE_BITS+1 +: IW];
  assign nd_c1    = rd_data[VALUE_BITS+1+IW +: IW];
  assign nd_next  = sh_bit ? nd_c1 : nd_c0;
  assign root_sel = in_is_ipv6 ? root_v6_r : root_v4_r;
  assign in_width = in_is_ipv6 ? btlpm_pkg::V6_BITS : btlpm_pkg::V4_BITS;
  assign nf_idx   = next_free_r[IW-1:0];
  assign nf_plus  = nf_idx + IW'(1);

  // Nodes still to allocate, and the pool bound
  assign needed    = root_empty_r ? (plen_r + 8'd1) : (plen_r - depth_r);
  assign pool_over = ({1'b0, next_free_r} + (CW + 1)'(needed)) > NODES_W;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'd0, out_mv_r, out_hit_r};

  btlpm_node_ram #(
    .DEPTH (NODES),
    .AW    (IW),
    .DW    (NW)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  btlpm_addr_shift u_addr_shift (
    .clk       (clk),
    .ctrl      (sh_ctrl),
    .load_addr ({in_addr_high, in_addr_low}),
    .msb       (sh_bit)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    root_v4_nxt    = root_v4_r;
    root_v6_nxt    = root_v6_r;
    next_free_nxt  = next_free_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_status_nxt = out_status_r;
    out_hit_nxt    = out_hit_r;
    out_mv_nxt     = out_mv_r;
    is_v6_nxt      = is_v6_r;
    plen_nxt       = plen_r;
    width_nxt      = width_r;
    depth_nxt      = depth_r;
    val_nxt        = val_r;
    cur_nxt        = cur_r;
    root_empty_nxt = root_empty_r;
    hit_nxt        = hit_r;
    mval_nxt       = mval_r;
    status_nxt     = status_r;
    rd_en          = 1'b0;
    rd_addr        = cur_r;
    wr_en          = 1'b0;
    wr_addr        = cur_r;
    wr_data        = rd_data;
    sh_ctrl        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          is_v6_nxt      = in_is_ipv6;
          plen_nxt       = in_prefix_len;
          width_nxt      = in_width;
          depth_nxt      = 8'd0;
          val_nxt        = VALUE_BITS'(in_value);
          cur_nxt        = root_sel;
          root_empty_nxt = (root_sel == NULL_IDX);
          hit_nxt        = 1'b0;
          mval_nxt       = ZERO_VAL;
          status_nxt     = btlpm_pkg::STATUS_DONE;
          sh_ctrl.load   = 1'b1;
          rd_addr        = root_sel;
          state_nxt      = ST_DONE;
          unique case (in_op)
            btlpm_pkg::OP_INSERT: begin
              if (in_prefix_len > in_width) begin
                status_nxt = btlpm_pkg::STATUS_TOO_LONG;
              end else if (root_sel == NULL_IDX) begin
                state_nxt = ST_IN_CHECK;
              end else begin
                rd_en     = 1'b1;
                state_nxt = ST_IN_WALK;
              end
            end
            btlpm_pkg::OP_LOOKUP: begin
              if (root_sel != NULL_IDX) begin
                rd_en     = 1'b1;
                state_nxt = ST_LK_WALK;
              end
            end
            btlpm_pkg::OP_CLEAR: begin
              root_v4_nxt   = NULL_IDX;
              root_v6_nxt   = NULL_IDX;
              next_free_nxt = CW'(1);
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      // Lookup: note each valued node, follow the address bit
      ST_LK_WALK: begin
        if (nd_hv) begin
          hit_nxt  = 1'b1;
          mval_nxt = nd_val;
        end
        if (depth_r == width_r || nd_next == NULL_IDX) begin
          state_nxt = ST_DONE;
        end else begin
          rd_en         = 1'b1;
          rd_addr       = nd_next;
          cur_nxt       = nd_next;
          depth_nxt     = depth_r + 8'd1;
          sh_ctrl.shift = 1'b1;
        end
      end

      // Insert: find the deepest existing node on the prefix path
      ST_IN_WALK: begin
        if (depth_r == plen_r || nd_next == NULL_IDX) begin
          state_nxt = ST_IN_CHECK;
        end else begin
          rd_en         = 1'b1;
          rd_addr       = nd_next;
          cur_nxt       = nd_next;
          depth_nxt     = depth_r + 8'd1;
          sh_ctrl.shift = 1'b1;
        end
      end

      // Insert: pool check, then value, root or link
      ST_IN_CHECK: begin
        if (pool_over) begin
          status_nxt = btlpm_pkg::STATUS_FULL;
          state_nxt  = ST_DONE;
        end else if (needed == 8'd0) begin
          state_nxt = ST_DONE;
          if (nd_hv) begin
            status_nxt = btlpm_pkg::STATUS_KEPT;
          end else begin
            wr_en      = 1'b1;
            wr_data    = {nd_c1, nd_c0, 1'b1, val_r};
            status_nxt = btlpm_pkg::STATUS_INSERTED;
          end
        end else if (root_empty_r) begin
          if (is_v6_r) begin
            root_v6_nxt = nf_idx;
          end else begin
            root_v4_nxt = nf_idx;
          end
          state_nxt = ST_IN_ALLOC;
        end else begin
          state_nxt = ST_IN_LINK;
        end
      end

      // Insert: hook the first new node under the deepest existing one
      ST_IN_LINK: begin
        wr_en = 1'b1;
        if (sh_bit) begin
          wr_data = {nf_idx, nd_c0, nd_hv, nd_val};
        end else begin
          wr_data = {nd_c1, nf_idx, nd_hv, nd_val};
        end
        depth_nxt     = depth_r + 8'd1;
        sh_ctrl.shift = 1'b1;
        state_nxt     = ST_IN_ALLOC;
      end

      // Insert: new nodes are consecutive, each links to the next
      ST_IN_ALLOC: begin
        wr_en         = 1'b1;
        wr_addr       = nf_idx;
        next_free_nxt = next_free_r + CW'(1);
        if (depth_r == plen_r) begin
          wr_data    = {NULL_IDX, NULL_IDX, 1'b1, val_r};
          status_nxt = btlpm_pkg::STATUS_INSERTED;
          state_nxt  = ST_DONE;
        end else begin
          if (sh_bit) begin
            wr_data = {nf_plus, NULL_IDX, 1'b0, ZERO_VAL};
          end else begin
            wr_data = {NULL_IDX, nf_plus, 1'b0, ZERO_VAL};
          end
          depth_nxt     = depth_r + 8'd1;
          sh_ctrl.shift = 1'b1;
        end
      end

      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_hit_nxt    = hit_r;
          out_mv_nxt     = 32'(mval_r);
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      root_v4_r   <= NULL_IDX;
      root_v6_r   <= NULL_IDX;
      next_free_r <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      root_v4_r   <= root_v4_nxt;
      root_v6_r   <= root_v6_nxt;
      next_free_r <= next_free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    is_v6_r      <= is_v6_nxt;
    plen_r       <= plen_nxt;
    width_r      <= width_nxt;
    depth_r      <= depth_nxt;
    val_r        <= val_nxt;
    cur_r        <= cur_nxt;
    root_empty_r <= root_empty_nxt;
    hit_r        <= hit_nxt;
    mval_r       <= mval_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_hit_r    <= out_hit_nxt;
    out_mv_r     <= out_mv_nxt;
  end

  // Checks
  `BTLPM_ASSERT_IMPL(a_no_null_write, wr_en, wr_addr != NULL_IDX, "write to null node")
  `BTLPM_ASSERT_IMPL(a_alloc_in_pool, state_r == ST_IN_ALLOC, {1'b0, next_free_r} < NODES_W, "allocation beyond pool")
  `BTLPM_ASSERT_NEXT(a_alloc_step, state_r == ST_IN_ALLOC, next_free_r == $past(next_free_r) + CW'(1), "free pointer did not advance")
  `BTLPM_ASSERT_IMPL(a_lookup_depth, state_r == ST_LK_WALK, depth_r <= width_r, "lookup walked past address width")
  `BTLPM_ASSERT_IMPL(a_hit_status, out_valid_r && out_hit_r, out_status_r == btlpm_pkg::STATUS_DONE, "hit on a non-lookup result")

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for binary_trie_longest_prefix_match_unit: inserts, lookups and clears
// go in over the input stream, and each result is checked against a trie predictor in the bench.
// Depends on btlpm_pkg and the RTL of the unit.
`default_nettype none

module testbench;

  localparam int NODES          = 4096;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 200;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int LONG_STALL     = 300;
  localparam int MAX_ROUTES     = 64;

  typedef struct packed {
    logic [1:0]   op;
    logic         v6;
    logic [127:0] addr;
    logic [7:0]   plen;
    logic [31:0]  val;
  } lpm_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        hit;
    logic [31:0] value;
  } lpm_resp_t;

  typedef struct {
    logic         v6;
    logic [127:0] addr;
    int           plen;
  } route_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [btlpm_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [btlpm_pkg::IN_USER_W-1:0]  in_tuser = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [btlpm_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [btlpm_pkg::OUT_USER_W-1:0] out_tuser;

  // Predictor state: node pool, roots (index 0 IPv4, 1 IPv6) and free pointer
  logic [11:0] link_zero [NODES];
  logic [11:0] link_one  [NODES];
  logic        valued    [NODES];
  logic [31:0] node_val  [NODES];
  int          trie_root [2] = '{0, 0};
  int          free_idx = 1;

  lpm_resp_t   expected_results [$];
  route_t      known_routes [$];
  lpm_resp_t   want;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int          stall_request = 0;
  int          stall_left = 0;
  bit          idle_en = 1'b1;

  binary_trie_longest_prefix_match_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // IPv4 address in the top 32 bits, junk below to keep the unused bits moving
  function automatic logic [127:0] v4_addr(input logic [31:0] a);
    return {a, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [127:0] prefix_mask(input int plen);
    return ~((128'd1 << (128 - plen)) - 128'd1);
  endfunction

  function automatic lpm_req_t make_req(input logic [1:0] op, input logic v6,
                                        input logic [127:0] addr, input int plen,
                                        input logic [31:0] val);
    lpm_req_t req;
    req.op   = op;
    req.v6   = v6;
    req.addr = addr;
    req.plen = 8'(plen);
    req.val  = val;
    return req;
  endfunction

  // Follow existing links from a non-empty root; returns depth reached
  function automatic int walk_depth(input logic v6, input logic [127:0] addr, input int limit,
                                    output int node);
    int d;
    int nxt;
    d    = 0;
    node = trie_root[v6];
    while (d < limit) begin
      nxt = addr[127 - d] ? link_one[node] : link_zero[node];
      if (nxt == 0) break;
      node = nxt;
      d++;
    end
    return d;
  endfunction

  function automatic int take_node();
    int n;
    n = free_idx;
    free_idx++;
    link_zero[n] = '0;
    link_one[n]  = '0;
    valued[n]    = 1'b0;
    node_val[n]  = '0;
    return n;
  endfunction

  function automatic lpm_resp_t lpm_predict(input lpm_req_t req);
    lpm_resp_t r;
    int width;
    int needed;
    int node;
    int nxt;
    int d;
    r.status = btlpm_pkg::STATUS_DONE;
    r.hit    = 1'b0;
    r.value  = '0;
    width    = req.v6 ? 128 : 32;
    case (req.op)
      btlpm_pkg::OP_INSERT: begin
        if (int'(req.plen) > width) begin
          r.status = btlpm_pkg::STATUS_TOO_LONG;
        end else begin
          // count new nodes first; a full pool leaves the tries untouched
          if (trie_root[req.v6] == 0)
            needed = int'(req.plen) + 1;
          else
            needed = int'(req.plen) - walk_depth(req.v6, req.addr, req.plen, node);
          if (needed > NODES - free_idx) begin
            r.status = btlpm_pkg::STATUS_FULL;
          end else begin
            if (trie_root[req.v6] == 0) trie_root[req.v6] = take_node();
            node = trie_root[req.v6];
            for (d = 0; d < int'(req.plen); d++) begin
              nxt = req.addr[127 - d] ? link_one[node] : link_zero[node];
              if (nxt == 0) begin
                nxt = take_node();
                if (req.addr[127 - d]) link_one[node] = 12'(nxt);
                else link_zero[node] = 12'(nxt);
              end
              node = nxt;
            end
            if (valued[node]) begin
              r.status = btlpm_pkg::STATUS_KEPT;
            end else begin
              valued[node]   = 1'b1;
              node_val[node] = req.val;
              r.status       = btlpm_pkg::STATUS_INSERTED;
            end
          end
        end
      end
      btlpm_pkg::OP_LOOKUP: begin
        // deepest valued node wins; the walk stops at the address width
        node = trie_root[req.v6];
        d    = 0;
        while (node != 0) begin
          if (valued[node]) begin
            r.hit   = 1'b1;
            r.value = node_val[node];
          end
          if (d >= width) break;
          node = req.addr[127 - d] ? link_one[node] : link_zero[node];
          d++;
        end
      end
      btlpm_pkg::OP_CLEAR: begin
        trie_root[0] = 0;
        trie_root[1] = 0;
        free_idx     = 1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // One input transfer; the expectation is queued in acceptance order
  task automatic send_item(input lpm_req_t req, output lpm_resp_t exp);
    exp = lpm_predict(req);
    expected_results.push_back(exp);
    if (idle_en) begin
      while ($urandom_range(99) < 14) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {req.val, req.plen, req.addr[63:0], req.addr[127:64]};
    in_tuser  <= {req.v6, req.op};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic issue(input logic [1:0] op, input logic v6, input logic [127:0] addr,
                       input int plen, input logic [31:0] val);
    lpm_resp_t ignored;
    send_item(make_req(op, v6, addr, plen, val), ignored);
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Both tries empty, first value kept, zero-length and full-length prefixes,
  // over-long prefixes, the unused op and clear
  task automatic test_directed();
    issue(btlpm_pkg::OP_LOOKUP, 1'b0, v4_addr(32'h0A01_0203), 0, 32'h0);
    issue(btlpm_pkg::OP_LOOKUP, 1'b1, rand128(), 0, 32'h0);
    issue(btlpm_pkg::OP_INSERT, 1'b0, v4_addr(32'h0A00_0000), 8, 32'h0000_1111);
    issue(btlpm_pkg::OP_INSERT, 1'b0, v4_addr(32'h0AFF_0000), 8, 32'h0000_2222);
    issue(btlpm_pkg::OP_INSERT, 1'b0, v4_addr(32'h0A01_0000), 16, 32'h0000_3333);
    issue(btlpm_pkg::OP_LOOKUP, 1'b0, v4_addr(32'h0A01_0203), 0, 32'h0);
    issue(btlpm_pkg::OP_LOOKUP, 1'b0, v4_addr(32'h0A02_0304), 0, 32'h0);
    issue(btlpm_pkg::OP_LOOKUP, 1'b0, v4_addr(32'h0B00_0000), 0, 32'h0);
    issue(btlpm_pkg::OP_INSERT, 1'b0, v4_addr(32'h0000_0000), 0, 32'h0000_4444);
    issue(btlpm_pkg::OP_LOOKUP, 1'b0, v4_addr(32'h0B00_0000), 0, 32'h0);
    issue(btlpm_pkg::OP_INSERT, 1'b0, v4_addr(32'hFFFF_FFFF), 32, 32'hFFFF_FFFF);
    issue(btlpm_pkg::OP_LOOKUP, 1'b0, v4_addr(32'hFFFF_FFFF), 0, 32'h0);
    issue(btlpm_pkg::OP_INSERT, 1'b0, v4_addr(32'h0A00_0000), 33, 32'h0000_5555);
    issue(btlpm_pkg::OP_INSERT, 1'b0, v4_addr(32'h0A00_0000), 255, 32'h0000_5555);
    issue(btlpm_pkg::OP_INSERT, 1'b1, rand128(), 129, 32'h0000_6666);
    issue(btlpm_pkg::OP_INSERT, 1'b1, {128{1'b1}}, 128, 32'h0);
    issue(btlpm_pkg::OP_LOOKUP, 1'b1, {128{1'b1}}, 0, 32'h0);
    issue(btlpm_pkg::OP_INSERT, 1'b1, '0, 0, 32'h0000_0005);
    issue(btlpm_pkg::OP_LOOKUP, 1'b1, '0, 0, 32'h0);
    issue(btlpm_pkg::OP_LOOKUP, 1'b1, {64'hFFFF_FFFF_FFFF_FFFE, 64'h0}, 0, 32'h0);
    issue(OP_UNUSED, 1'b1, rand128(), 255, 32'hFFFF_FFFF);
    issue(btlpm_pkg::OP_CLEAR, 1'b0, rand128(), 0, 32'h0);
    issue(btlpm_pkg::OP_LOOKUP, 1'b0, v4_addr(32'h0A01_0203), 0, 32'h0);
    issue(btlpm_pkg::OP_LOOKUP, 1'b1, {128{1'b1}}, 0, 32'h0);
    issue(btlpm_pkg::OP_INSERT, 1'b0, v4_addr(32'h0A00_0000), 8, 32'h0000_7777);
  endtask

  // Fill the pool with long IPv6 routes, top it up to the last node, then
  // check that only inserts needing no new node still succeed
  task automatic test_pool_exhaustion();
    lpm_resp_t exp;
    logic [127:0] first_addr;
    logic [127:0] addr;
    int node;
    int d;
    int n;
    issue(btlpm_pkg::OP_CLEAR, 1'b0, '0, 0, 32'h0);
    first_addr = rand128();
    send_item(make_req(btlpm_pkg::OP_INSERT, 1'b1, first_addr, 128, $urandom), exp);
    do begin
      send_item(make_req(btlpm_pkg::OP_INSERT, 1'b1, rand128(), 128, $urandom), exp);
    end while (exp.status != btlpm_pkg::STATUS_FULL);
    while (free_idx < NODES) begin
      addr = rand128();
      d    = walk_depth(1'b1, addr, 128, node);
      n    = NODES - free_idx;
      if (n > 128 - d) n = 128 - d;
      send_item(make_req(btlpm_pkg::OP_INSERT, 1'b1, addr, d + n, $urandom), exp);
    end
    issue(btlpm_pkg::OP_INSERT, 1'b0, v4_addr($urandom), 0, $urandom);
    issue(btlpm_pkg::OP_INSERT, 1'b1, rand128(), 128, $urandom);
    issue(btlpm_pkg::OP_INSERT, 1'b1, first_addr, 64, $urandom);
    issue(btlpm_pkg::OP_INSERT, 1'b1, first_addr, 128, $urandom);
    issue(btlpm_pkg::OP_LOOKUP, 1'b1, first_addr, 0, 32'h0);
    issue(btlpm_pkg::OP_LOOKUP, 1'b1, {first_addr[127:64], $urandom, $urandom}, 0, 32'h0);
    issue(btlpm_pkg::OP_LOOKUP, 1'b0, v4_addr($urandom), 0, 32'h0);
    issue(btlpm_pkg::OP_CLEAR, 1'b1, '0, 0, 32'h0);
    issue(btlpm_pkg::OP_INSERT, 1'b0, v4_addr($urandom), 0, $urandom);
    issue(btlpm_pkg::OP_LOOKUP, 1'b0, v4_addr($urandom), 0, 32'h0);
  endtask

  // Receiver stalls long enough for the unit to back up its input, then the
  // sender waits for every result before going on
  task automatic test_backpressure();
    int i;
    stall_request = LONG_STALL;
    for (i = 0; i < 16; i++) begin
      if (i[0])
        issue(btlpm_pkg::OP_INSERT, 1'b0, v4_addr($urandom), $urandom_range(32),
              $urandom);
      else
        issue(btlpm_pkg::OP_LOOKUP, 1'b0, v4_addr($urandom), 0, 32'h0);
    end
    wait_results_drained();
    for (i = 0; i < 6; i++)
      issue(btlpm_pkg::OP_LOOKUP, 1'b0, v4_addr($urandom), 0, 32'h0);
    wait_results_drained();
  endtask

  // Mostly inserts that extend known routes and lookups that land under them,
  // with noise, over-long prefixes, the unused op and occasional clears
  task automatic test_random();
    lpm_resp_t exp;
    route_t base;
    logic [1:0] op;
    logic v6;
    logic [127:0] addr;
    logic [127:0] m;
    int width;
    int plen;
    int r;
    int flip;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_en = !(i >= 600 && i < 900);
      r     = $urandom_range(99);
      v6    = 1'($urandom_range(1));
      width = v6 ? 128 : 32;
      addr  = rand128();
      plen  = $urandom_range(255);
      if (r < 2 || (free_idx > 3800 && $urandom_range(7) == 0)) begin
        op = btlpm_pkg::OP_CLEAR;
      end else if (r < 4) begin
        op = OP_UNUSED;
      end else if (r < 7) begin
        op   = btlpm_pkg::OP_INSERT;
        plen = $urandom_range(255, width + 1);
      end else if (r < 42) begin
        op = btlpm_pkg::OP_INSERT;
        if (known_routes.size() != 0 && $urandom_range(3) != 0) begin
          base  = known_routes[$urandom_range(known_routes.size() - 1)];
          v6    = base.v6;
          width = v6 ? 128 : 32;
          if ($urandom_range(4) == 0) plen = $urandom_range(base.plen);
          else plen = base.plen + $urandom_range(12);
          if (plen > width) plen = width;
          m    = prefix_mask(base.plen);
          addr = (base.addr & m) | (addr & ~m);
        end else if (v6) begin
          plen = ($urandom_range(3) == 0) ? $urandom_range(128) : $urandom_range(40);
        end else begin
          plen = $urandom_range(32);
        end
      end else begin
        op = btlpm_pkg::OP_LOOKUP;
        if (known_routes.size() != 0 && $urandom_range(9) < 7) begin
          base = known_routes[$urandom_range(known_routes.size() - 1)];
          v6   = base.v6;
          m    = prefix_mask(base.plen);
          addr = (base.addr & m) | (addr & ~m);
          // a near miss: one bit flipped inside the prefix
          if (base.plen > 0 && $urandom_range(9) == 0) begin
            flip       = 127 - int'($urandom_range(base.plen - 1));
            addr[flip] = ~addr[flip];
          end
        end
      end
      send_item(make_req(op, v6, addr, plen, $urandom), exp);
      if (op == btlpm_pkg::OP_CLEAR) begin
        known_routes.delete();
      end else if (op == btlpm_pkg::OP_INSERT &&
                   (exp.status == btlpm_pkg::STATUS_INSERTED ||
                    exp.status == btlpm_pkg::STATUS_KEPT)) begin
        base.v6   = v6;
        base.addr = addr;
        base.plen = plen;
        known_routes.push_back(base);
        if (known_routes.size() > MAX_ROUTES) void'(known_routes.pop_front());
      end
    end
    idle_en = 1'b1;
  endtask

  // ---------------------------------------------------------------- checking

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Result receiver: random idling, plus a long hold-off on request
  always @(posedge clk) begin
    if (stall_request != 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(idle_en && $urandom_range(99) < 14);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: status %0d", out_tuser);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_tuser[2:0]));
        check_field("hit", 32'(want.hit), 32'(out_tdata[0]));
        check_field("match_value", want.value, out_tdata[32:1]);
      end
    end
  end

  // Watchdog: cycles with work outstanding but no transfer on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (expected_results.size() == 0 && !in_tvalid))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_pool_exhaustion();
    test_backpressure();
    test_random();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
+incdir+rtl
rtl/btlpm_pkg.sv
rtl/btlpm_node_ram.sv
rtl/btlpm_addr_shift.sv
rtl/binary_trie_longest_prefix_match_unit.sv
tb/sv/testbench.sv
